[src/ckc_pkg.sv]
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types and constants of the color key centroid unit.
// ----------------------------------------------------------------------------
package ckc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CHAN_W   = 8;
    localparam int COORD_W  = 10;
    localparam int LIMIT_W  = 10;
    localparam int DIST_W   = 10;
    localparam int SUM_W    = 30;
    localparam int CNT_W    = 21;
    localparam int ITER_W   = $clog2(SUM_W);
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 10;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 24;

    typedef enum logic [IDX_W-1:0] {
        REG_KEY_BLUE    = 2'd0,
        REG_KEY_GREEN   = 2'd1,
        REG_KEY_RED     = 2'd2,
        REG_MATCH_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic step;
        logic load_out;
    } t_cmd;

endpackage

[src/ckc_ctrl.sv]
// ----------------------------------------------------------------------------
// ckc_ctrl
// Controller: sequences pixel intake, the serial division and the result hold.
// ----------------------------------------------------------------------------
module ckc_ctrl
    import ckc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_ACCUM = 3'b001,
        ST_DIV   = 3'b010,
        ST_FIN   = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic                r_out_valid, n_out_valid;
    logic                out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_ACCUM);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_ACCUM: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.load_div = 1'b1;
                    n_iter         = '0;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_iter     = r_iter + 1'b1;
                if (r_iter == ITER_W'(SUM_W - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[src/ckc_dp.sv]
// ----------------------------------------------------------------------------
// ckc_dp
// Datapath: key registers, color distance, coordinate sums and two
// restoring dividers that share one divisor.
// ----------------------------------------------------------------------------
module ckc_dp
    import ckc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [CHAN_W-1:0]  i_blue,
    input  logic [CHAN_W-1:0]  i_green,
    input  logic [CHAN_W-1:0]  i_red,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    output logic [COORD_W-1:0] o_centre_col,
    output logic [COORD_W-1:0] o_centre_row,
    output logic               o_found
);

    logic [CHAN_W-1:0]  r_key_blue, r_key_green, r_key_red;
    logic [LIMIT_W-1:0] r_match_limit;
    logic [SUM_W-1:0]   r_col_sum, r_row_sum, n_col_sum, n_row_sum;
    logic [CNT_W-1:0]   r_hit_count, n_hit_count;
    logic [SUM_W-1:0]   r_dvd_col, r_dvd_row;
    logic [CNT_W-1:0]   r_rem_col, r_rem_row, r_divisor;
    logic [COORD_W-1:0] r_out_col, r_out_row;
    logic               r_out_found;
    logic [CHAN_W-1:0]  d_blue, d_green, d_red;
    logic [DIST_W-1:0]  distance;
    logic               in_window, hit;
    logic [CNT_W:0]     sh_col, sh_row;
    logic               ge_col, ge_row;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    assign d_blue    = abs_diff(i_blue, r_key_blue);
    assign d_green   = abs_diff(i_green, r_key_green);
    assign d_red     = abs_diff(i_red, r_key_red);
    assign distance  = DIST_W'(d_blue) + DIST_W'(d_green) + DIST_W'(d_red);
    assign in_window = (32'(i_col) < MAX_WIDTH) && (32'(i_row) < MAX_HEIGHT);
    assign hit       = in_window && (distance < r_match_limit);

    always_comb begin
        n_col_sum   = r_col_sum;
        n_row_sum   = r_row_sum;
        n_hit_count = r_hit_count;
        if (hit) begin
            n_col_sum   = r_col_sum + SUM_W'(i_col);
            n_row_sum   = r_row_sum + SUM_W'(i_row);
            n_hit_count = r_hit_count + 1'b1;
        end
    end

    assign sh_col = {r_rem_col, r_dvd_col[SUM_W-1]};
    assign sh_row = {r_rem_row, r_dvd_row[SUM_W-1]};
    assign ge_col = sh_col >= {1'b0, r_divisor};
    assign ge_row = sh_row >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_blue    <= '0;
            r_key_green   <= '0;
            r_key_red     <= '0;
            r_match_limit <= '0;
            r_col_sum     <= '0;
            r_row_sum     <= '0;
            r_hit_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_KEY_BLUE:    r_key_blue    <= i_cfg_data[CHAN_W-1:0];
                    REG_KEY_GREEN:   r_key_green   <= i_cfg_data[CHAN_W-1:0];
                    REG_KEY_RED:     r_key_red     <= i_cfg_data[CHAN_W-1:0];
                    REG_MATCH_LIMIT: r_match_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_div) begin
                r_col_sum   <= '0;
                r_row_sum   <= '0;
                r_hit_count <= '0;
            end else if (i_cmd.accept) begin
                r_col_sum   <= n_col_sum;
                r_row_sum   <= n_row_sum;
                r_hit_count <= n_hit_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_dvd_col <= n_col_sum;
            r_dvd_row <= n_row_sum;
            r_divisor <= n_hit_count;
            r_rem_col <= '0;
            r_rem_row <= '0;
        end else if (i_cmd.step) begin
            r_dvd_col <= {r_dvd_col[SUM_W-2:0], ge_col};
            r_dvd_row <= {r_dvd_row[SUM_W-2:0], ge_row};
            r_rem_col <= ge_col ? CNT_W'(sh_col - {1'b0, r_divisor}) : sh_col[CNT_W-1:0];
            r_rem_row <= ge_row ? CNT_W'(sh_row - {1'b0, r_divisor}) : sh_row[CNT_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_found <= (r_divisor != '0);
            r_out_col   <= (r_divisor != '0) ? r_dvd_col[COORD_W-1:0] : '0;
            r_out_row   <= (r_divisor != '0) ? r_dvd_row[COORD_W-1:0] : '0;
        end
    end

    assign o_centre_col = r_out_col;
    assign o_centre_row = r_out_row;
    assign o_found      = r_out_found;

endmodule

[src/color_key_centroid_unit.sv]
// ----------------------------------------------------------------------------
// color_key_centroid_unit
// Color key blob centroid over a window of pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel, one transaction per pixel and one per
// cycle while the unit accumulates; s_axis_tlast marks the last pixel of a
// window. A pixel matches when its summed absolute channel difference to the
// key color is below the match limit, and matching pixels add to the column
// sum, the row sum and the hit count.
// After the last pixel, s_axis_tready stays low while two restoring
// dividers, one quotient bit per cycle, form the mean column and row,
// and until the result register is loaded. The result appears on
// m_axis; m_axis_tuser is low and the data zero when nothing matched.
// If the receiver stalls, the result holds and new pixels are still
// taken until the next window ends.
// Key registers are written over the cfg channel, which is always ready.
// Reset clears the key registers, the sums and the output valid.
// ----------------------------------------------------------------------------
module color_key_centroid_unit
    import ckc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // blue[7:0], green[15:8], red[23:16], col[33:24], row[43:34], zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // centre_col[9:0], centre_row[19:10], zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    // found[0]
    output logic              m_axis_tuser,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd               cmd;
    logic [COORD_W-1:0] centre_col, centre_row;

    assign o_cfg_ready = 1'b1;

    ckc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    ckc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_blue       (s_axis_tdata[7:0]),
        .i_green      (s_axis_tdata[15:8]),
        .i_red        (s_axis_tdata[23:16]),
        .i_col        (s_axis_tdata[33:24]),
        .i_row        (s_axis_tdata[43:34]),
        .o_centre_col (centre_col),
        .o_centre_row (centre_row),
        .o_found      (m_axis_tuser)
    );

    assign m_axis_tdata = {(OUT_W - 2*COORD_W)'(0), centre_row, centre_col};

endmodule

[src/ckc_checker.sv]
// ----------------------------------------------------------------------------
// ckc_checker
// Port level checks of the color key centroid unit, bound to the top level.
// ----------------------------------------------------------------------------
module ckc_checker
    import ckc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("result without match carries nonzero data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_busy_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("pixel taken while the division runs");

endmodule

bind color_key_centroid_unit ckc_checker u_ckc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
